>>> rtl/pfd_pkg.sv
package pfd_pkg;

  // frame geometry
  localparam int NUM_CHANNELS = 10;
  localparam int CNT_W        = $clog2(NUM_CHANNELS + 1);
  localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // edge queue between front and back
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  // register reset values
  localparam logic [15:0] MIN_WIDTH_RST  = 16'd800;
  localparam logic [15:0] MAX_WIDTH_RST  = 16'd2200;
  localparam logic [15:0] RESYNC_GAP_RST = 16'd3000;
  localparam logic [15:0] START_GAP_RST  = 16'd2500;

  typedef enum logic [1:0] {
    REG_MIN_WIDTH  = 2'd0,
    REG_MAX_WIDTH  = 2'd1,
    REG_RESYNC_GAP = 2'd2,
    REG_START_GAP  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] min_width;
    logic [15:0] max_width;
    logic [15:0] resync_gap;
    logic [15:0] start_gap;
  } cfg_t;

  // classified edge: compare results plus low half of the interval
  typedef struct packed {
    logic        in_window;
    logic        ge_resync;
    logic        ge_start;
    logic [15:0] pulse;
  } edge_t;

endpackage

>>> rtl/pfd_front.sv
module pfd_front import pfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] timestamp_i,
  output logic        push_o,
  output edge_t       edge_o,
  input  logic        full_i
);

  logic [31:0] prev_time_q, prev_time_d;
  logic [31:0] interval_q, interval_d;
  logic        hold_q, hold_d;
  logic        accept;

  assign push_o     = hold_q && !full_i;
  assign in_ready_o = !hold_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    prev_time_d = prev_time_q;
    interval_d  = interval_q;
    hold_d      = hold_q && !push_o;
    if (accept) begin
      prev_time_d = timestamp_i;
      interval_d  = timestamp_i - prev_time_q;  // wraps modulo 2^32
      hold_d      = 1'b1;
    end
  end

  always_comb begin
    edge_o.in_window = (interval_q >= {16'd0, cfg_i.min_width}) &&
                       (interval_q <= {16'd0, cfg_i.max_width});
    edge_o.ge_resync = interval_q >= {16'd0, cfg_i.resync_gap};
    edge_o.ge_start  = interval_q >= {16'd0, cfg_i.start_gap};
    edge_o.pulse     = interval_q[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= '0;
      hold_q      <= 1'b0;
    end else begin
      prev_time_q <= prev_time_d;
      hold_q      <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    interval_q <= interval_d;
  end

endmodule

>>> rtl/pfd_queue.sv
module pfd_queue import pfd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  edge_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output edge_t data_o,
  output logic  empty_o
);

  edge_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/pfd_back.sv
module pfd_back import pfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  edge_t       edge_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  channel_index_o,
  output logic [15:0] pulse_o,
  output logic        last_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic             in_sync_q;
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] emit_idx_q;
  logic [15:0]      store_q [NUM_CHANNELS];
  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [15:0]      out_pulse_q;
  logic             out_last_q;
  logic             slot_free;
  logic             emit_last;
  logic             store_we;

  assign pop_o     = (state_q == ST_IDLE) && !empty_i;
  assign slot_free = !out_valid_q || out_ready_i;
  assign emit_last = emit_idx_q == IDX_W'(NUM_CHANNELS - 1);
  assign store_we  = pop_o && in_sync_q && edge_i.in_window &&
                     (count_q < CNT_W'(NUM_CHANNELS));

  assign out_valid_o     = out_valid_q;
  assign channel_index_o = 4'(out_idx_q);
  assign pulse_o         = out_pulse_q;
  assign last_o          = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_sync_q   <= 1'b0;
      count_q     <= '0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_EMIT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            if (in_sync_q) begin
              if (edge_i.in_window) begin
                if (count_q < CNT_W'(NUM_CHANNELS)) begin
                  count_q <= count_q + 1'b1;
                  if (count_q == CNT_W'(NUM_CHANNELS - 1)) begin
                    in_sync_q  <= 1'b0;
                    emit_idx_q <= '0;
                    state_q    <= ST_EMIT;
                  end
                end
              end else if (edge_i.ge_resync) begin
                count_q <= '0;
              end else begin
                in_sync_q <= 1'b0;
              end
            end else if (edge_i.ge_start) begin
              in_sync_q <= 1'b1;
              count_q   <= '0;
            end
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            emit_idx_q <= emit_idx_q + 1'b1;
            if (emit_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q[IDX_W-1:0]] <= edge_i.pulse;
    end
    if (state_q == ST_EMIT && slot_free) begin
      out_idx_q   <= emit_idx_q;
      out_pulse_q <= store_q[emit_idx_q];
      out_last_q  <= emit_last;
    end
  end

endmodule

>>> rtl/ppm_frame_decoder_core.sv
// PPM frame decoder: timestamped edges in, channel pulse widths out.
// Path: an edge is registered in the front and held in the queue until the back
//   end pops it into the decoder state; the first result of a frame is then registered.
// Throughput: one edge per cycle while no frame is being sent; a completed
//   frame holds the back end for NUM_CHANNELS (10) output transfers.
// Reset: rst_ni asynchronous, active low; control registers return to defaults.
module ppm_frame_decoder_core import pfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // edge input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] timestamp_us
  // channel results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [3:0] channel_index, [19:4] pulse_us, [23:20] 0
  output logic        m_axis_tlast_o,   // frame_last
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg_q;
  reg_idx_e    reg_sel;
  logic        cfg_we;

  edge_t       front_edge;
  logic        front_push;
  logic        queue_full;
  edge_t       queue_edge;
  logic        queue_empty;
  logic        back_pop;
  logic [3:0]  res_index;
  logic [15:0] res_pulse;

  // Register file: byte address 4*i, low address bits ignored.
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      REG_MIN_WIDTH:  prdata = {16'd0, cfg_q.min_width};
      REG_MAX_WIDTH:  prdata = {16'd0, cfg_q.max_width};
      REG_RESYNC_GAP: prdata = {16'd0, cfg_q.resync_gap};
      REG_START_GAP:  prdata = {16'd0, cfg_q.start_gap};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_width  <= MIN_WIDTH_RST;
      cfg_q.max_width  <= MAX_WIDTH_RST;
      cfg_q.resync_gap <= RESYNC_GAP_RST;
      cfg_q.start_gap  <= START_GAP_RST;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_MIN_WIDTH:  cfg_q.min_width  <= pwdata[15:0];
        REG_MAX_WIDTH:  cfg_q.max_width  <= pwdata[15:0];
        REG_RESYNC_GAP: cfg_q.resync_gap <= pwdata[15:0];
        REG_START_GAP:  cfg_q.start_gap  <= pwdata[15:0];
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  // Front: measures the interval since the last edge and classifies it.
  pfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .timestamp_i (s_axis_tdata_i),
    .push_o      (front_push),
    .edge_o      (front_edge),
    .full_i      (queue_full)
  );

  // Short queue so edges keep flowing while a frame is sent, until the queue fills.
  pfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_edge),
    .full_o  (queue_full),
    .pop_i   (back_pop),
    .data_o  (queue_edge),
    .empty_o (queue_empty)
  );

  // Back: sync tracking, channel store and frame output.
  pfd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .edge_i          (queue_edge),
    .empty_i         (queue_empty),
    .pop_o           (back_pop),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .channel_index_o (res_index),
    .pulse_o         (res_pulse),
    .last_o          (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'd0, res_pulse, res_index};

endmodule
